>>> hdl/oah_pkg.sv
package oah_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int SIZE_W     = 7;
    localparam int KEY_W      = 31;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int DIV_CNT_W  = $clog2(KEY_W);

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXISTS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_EXISTS = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd6;

    localparam logic [0:0] REG_PROBE_MODE = 1'b0;
    localparam logic [0:0] REG_TABLE_SIZE = 1'b1;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_USED  = 2'd1,
        MARK_GONE  = 2'd2
    } t_mark;

    typedef struct packed {
        logic              mark_we;
        logic              key_we;
        logic [SLOT_W-1:0] addr;
        t_mark             mark;
        logic [KEY_W-1:0]  key;
    } t_store_wr;

endpackage

>>> hdl/oah_div.sv
module oah_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [oah_pkg::KEY_W-1:0]           i_dividend,
    input  logic [oah_pkg::SIZE_W-1:0]          i_divisor,
    output logic                                o_done,
    output logic [oah_pkg::SLOT_W-1:0]          o_rem
);

    logic                           r_run;
    logic                           r_done;
    logic [oah_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [oah_pkg::KEY_W-1:0]      r_dvd;
    logic [oah_pkg::SIZE_W-1:0]     r_dsr;
    logic [oah_pkg::SLOT_W-1:0]     r_rem;
    logic [oah_pkg::SLOT_W:0]       w_trial;
    logic [oah_pkg::SLOT_W:0]       w_diff;

    // one dividend bit per cycle is shifted into the remainder, MSB first
    assign w_trial = {r_rem, r_dvd[oah_pkg::KEY_W-1]};
    assign w_diff  = w_trial - (oah_pkg::SLOT_W+1)'(r_dsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == oah_pkg::DIV_CNT_W'(oah_pkg::KEY_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[oah_pkg::KEY_W-2:0], 1'b0};
            if (w_trial >= (oah_pkg::SLOT_W+1)'(r_dsr)) begin
                r_rem <= w_diff[oah_pkg::SLOT_W-1:0];
            end else begin
                r_rem <= w_trial[oah_pkg::SLOT_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> hdl/oah_store.sv
module oah_store (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [oah_pkg::SLOT_W-1:0]          i_rd_addr,
    input  oah_pkg::t_store_wr                  i_wr,
    output oah_pkg::t_mark                      o_rd_mark,
    output logic [oah_pkg::KEY_W-1:0]           o_rd_key
);

    logic [oah_pkg::KEY_W-1:0]   r_key_mem  [oah_pkg::SLOT_COUNT];
    oah_pkg::t_mark              r_mark_mem [oah_pkg::SLOT_COUNT];
    logic [oah_pkg::SLOT_COUNT-1:0] r_valid;
    logic                        r_rd_valid;
    oah_pkg::t_mark              r_rd_mark;
    logic [oah_pkg::KEY_W-1:0]   r_rd_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.mark_we) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.mark_we) begin
            r_mark_mem[i_wr.addr] <= i_wr.mark;
        end
        if (i_wr.key_we) begin
            r_key_mem[i_wr.addr] <= i_wr.key;
        end
        r_rd_valid <= r_valid[i_rd_addr];
        r_rd_mark  <= r_mark_mem[i_rd_addr];
        r_rd_key   <= r_key_mem[i_rd_addr];
    end

    // a slot never marked since reset reads as empty
    assign o_rd_mark = r_rd_valid ? r_rd_mark : oah_pkg::MARK_EMPTY;
    assign o_rd_key  = r_rd_key;

endmodule

>>> hdl/open_addressing_hash_table_top.sv
// A command runs from accepted start to o_valid over P probes (1 to table size): the command
// is latched, the bit-serial key modulo is launched and run to take the home slot, then each
// probe reads the store and checks the slot, and last the result is issued.
// One command at a time: a start is taken only while idle; busy drops in the cycle of the result beat.
// The result beat is a one-cycle strobe on o_valid; the receiver cannot stall it.
// Reset (synchronous, active low) empties all slots, sets linear probing and size 64.
module open_addressing_hash_table_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [oah_pkg::CMD_W-1:0]           i_command,
    input  logic [oah_pkg::KEY_W-1:0]           i_key,
    input  logic                                i_cfg_we,
    input  logic [0:0]                          i_cfg_idx,
    input  logic [oah_pkg::SIZE_W-1:0]          i_cfg_data,
    output logic                                o_valid,
    output logic [oah_pkg::STATUS_W-1:0]        o_status,
    output logic [oah_pkg::SLOT_W-1:0]          o_slot
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_EV,
        S_RES
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_probe_mode;
    logic [oah_pkg::SIZE_W-1:0]      r_table_size;
    logic [oah_pkg::SIZE_W-1:0]      w_eff_size;

    logic [oah_pkg::CMD_W-1:0]       r_cmd, n_cmd;
    logic [oah_pkg::KEY_W-1:0]       r_key, n_key;
    logic [oah_pkg::SIZE_W-1:0]      r_size, n_size;
    logic                            r_mode, n_mode;
    logic [oah_pkg::SLOT_W-1:0]      r_j, n_j;
    logic [oah_pkg::SLOT_W-1:0]      r_d, n_d;
    logic [oah_pkg::SIZE_W-1:0]      r_k, n_k;
    logic                            r_hit, n_hit;
    logic [oah_pkg::SLOT_W-1:0]      r_where, n_where;
    logic                            r_free_ok, n_free_ok;
    logic [oah_pkg::SLOT_W-1:0]      r_free, n_free;
    logic                            r_out_valid, n_out_valid;
    logic [oah_pkg::STATUS_W-1:0]    r_status, n_status;
    logic [oah_pkg::SLOT_W-1:0]      r_slot, n_slot;

    logic                            w_div_start;
    logic                            w_div_done;
    logic [oah_pkg::SLOT_W-1:0]      w_home;
    oah_pkg::t_store_wr              w_wr;
    oah_pkg::t_mark                  w_rd_mark;
    logic [oah_pkg::KEY_W-1:0]       w_rd_key;

    logic [oah_pkg::SIZE_W-1:0]      w_j_sum;
    logic [oah_pkg::SIZE_W-1:0]      w_d_sum;
    logic [oah_pkg::SLOT_W-1:0]      w_j_next;
    logic [oah_pkg::SLOT_W-1:0]      w_d_next;
    logic [oah_pkg::SIZE_W-1:0]      w_k_inc;

    oah_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_key),
        .i_divisor  (r_size),
        .o_done     (w_div_done),
        .o_rem      (w_home)
    );

    oah_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_j),
        .i_wr      (w_wr),
        .o_rd_mark (w_rd_mark),
        .o_rd_key  (w_rd_key)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_mode <= 1'b0;
            r_table_size <= oah_pkg::SIZE_W'(oah_pkg::SLOT_COUNT);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                oah_pkg::REG_PROBE_MODE: r_probe_mode <= i_cfg_data[0];
                oah_pkg::REG_TABLE_SIZE: r_table_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_table_size == '0) begin
            w_eff_size = oah_pkg::SIZE_W'(1);
        end else if (r_table_size > oah_pkg::SIZE_W'(oah_pkg::SLOT_COUNT)) begin
            w_eff_size = oah_pkg::SIZE_W'(oah_pkg::SLOT_COUNT);
        end else begin
            w_eff_size = r_table_size;
        end
    end

    // next probe slot: add the step (1, or 2k+1 for quadratic), wrap by one subtract
    assign w_j_sum  = oah_pkg::SIZE_W'(r_j) + (r_mode ? oah_pkg::SIZE_W'(r_d)
                                                       : oah_pkg::SIZE_W'(1));
    assign w_j_next = (w_j_sum >= r_size) ? oah_pkg::SLOT_W'(w_j_sum - r_size)
                                          : oah_pkg::SLOT_W'(w_j_sum);
    assign w_d_sum  = oah_pkg::SIZE_W'(r_d) + oah_pkg::SIZE_W'(2);
    assign w_d_next = (w_d_sum >= r_size) ? oah_pkg::SLOT_W'(w_d_sum - r_size)
                                          : oah_pkg::SLOT_W'(w_d_sum);
    assign w_k_inc  = r_k + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_size      = r_size;
        n_mode      = r_mode;
        n_j         = r_j;
        n_d         = r_d;
        n_k         = r_k;
        n_hit       = r_hit;
        n_where     = r_where;
        n_free_ok   = r_free_ok;
        n_free      = r_free;
        n_out_valid = 1'b0;
        n_status    = r_status;
        n_slot      = r_slot;
        w_div_start = 1'b0;
        w_wr        = '0;
        w_wr.mark   = oah_pkg::MARK_EMPTY;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_command;
                    n_key   = i_key;
                    n_size  = w_eff_size;
                    n_mode  = r_probe_mode;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // kick the divider on the first cycle here, wait for the home slot
                w_div_start = (r_k == oah_pkg::SIZE_W'(0)) && !r_hit;
                n_hit       = 1'b1;
                if (w_div_done) begin
                    n_j       = w_home;
                    n_d       = (r_size == oah_pkg::SIZE_W'(1)) ? '0 : oah_pkg::SLOT_W'(1);
                    n_k       = '0;
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                    n_state   = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (w_rd_mark == oah_pkg::MARK_EMPTY) begin
                    if (!r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_j;
                    end
                    n_state = S_RES;
                end else if (w_rd_mark == oah_pkg::MARK_USED && w_rd_key == r_key) begin
                    n_hit   = 1'b1;
                    n_where = r_j;
                    n_state = S_RES;
                end else begin
                    if (w_rd_mark != oah_pkg::MARK_USED && !r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_j;
                    end
                    n_k = w_k_inc;
                    if (w_k_inc == r_size) begin
                        n_state = S_RES;
                    end else begin
                        n_j     = w_j_next;
                        n_d     = w_d_next;
                        n_state = S_RD;
                    end
                end
            end
            S_RES: begin
                n_out_valid = 1'b1;
                n_slot      = '0;
                case (r_cmd)
                    oah_pkg::CMD_INSERT: begin
                        if (r_hit) begin
                            n_status = oah_pkg::ST_EXISTS;
                            n_slot   = r_where;
                        end else if (r_free_ok) begin
                            w_wr.mark_we = 1'b1;
                            w_wr.key_we  = 1'b1;
                            w_wr.addr    = r_free;
                            w_wr.mark    = oah_pkg::MARK_USED;
                            w_wr.key     = r_key;
                            n_status     = oah_pkg::ST_INSERTED;
                            n_slot       = r_free;
                        end else begin
                            n_status = oah_pkg::ST_FULL;
                        end
                    end
                    oah_pkg::CMD_DELETE: begin
                        if (r_hit) begin
                            w_wr.mark_we = 1'b1;
                            w_wr.addr    = r_where;
                            w_wr.mark    = oah_pkg::MARK_GONE;
                            n_status     = oah_pkg::ST_DELETED;
                            n_slot       = r_where;
                        end else begin
                            n_status = oah_pkg::ST_NOT_EXISTS;
                        end
                    end
                    default: begin
                        if (r_hit) begin
                            n_status = oah_pkg::ST_FOUND;
                            n_slot   = r_where;
                        end else begin
                            n_status = oah_pkg::ST_NOT_FOUND;
                        end
                    end
                endcase
                n_hit   = 1'b0;
                n_k     = '0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_hit       <= 1'b0;
            r_free_ok   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
            r_hit       <= n_hit;
            r_free_ok   <= n_free_ok;
        end
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_size   <= n_size;
        r_mode   <= n_mode;
        r_j      <= n_j;
        r_d      <= n_d;
        r_where  <= n_where;
        r_free   <= n_free;
        r_status <= n_status;
        r_slot   <= n_slot;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_slot   = r_slot;

    a_valid_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV) |-> (r_k < r_size) && (oah_pkg::SIZE_W'(r_j) < r_size))
        else $error("probe outside table");

    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == oah_pkg::ST_FULL || o_status == oah_pkg::ST_NOT_EXISTS
                     || o_status == oah_pkg::ST_NOT_FOUND)) |-> (o_slot == '0))
        else $error("miss reported with nonzero slot");

endmodule

>>> tb/sv/open_addressing_hash_table_top_tb.sv
`timescale 1ns / 100ps

module open_addressing_hash_table_top_tb;

    localparam logic [oah_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int N_PHASES  = 12;
    localparam int PER_PHASE = 58;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [oah_pkg::STATUS_W-1:0] status;
        logic [oah_pkg::SLOT_W-1:0]   slot;
    } t_reply;

    typedef struct packed {
        logic                      cfg;
        logic [oah_pkg::CMD_W-1:0] op;
        logic [oah_pkg::KEY_W-1:0] arg;
        logic                      typed;
        t_reply                    reply;
    } t_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [oah_pkg::CMD_W-1:0]    i_command;
    logic [oah_pkg::KEY_W-1:0]    i_key;
    logic                         i_cfg_we;
    logic [0:0]                   i_cfg_idx;
    logic [oah_pkg::SIZE_W-1:0]   i_cfg_data;
    logic                         o_valid;
    logic [oah_pkg::STATUS_W-1:0] o_status;
    logic [oah_pkg::SLOT_W-1:0]   o_slot;

    // shadow of the hash store and its registers
    logic [oah_pkg::KEY_W-1:0]  tbl_key [oah_pkg::SLOT_COUNT];
    oah_pkg::t_mark             tbl_mark [oah_pkg::SLOT_COUNT];
    logic                       cfg_quad;
    logic [oah_pkg::SIZE_W-1:0] cfg_size;

    t_reply                    replies_due [$];
    t_row                      directed_rows [$];
    logic [oah_pkg::KEY_W-1:0] key_pool [$];
    t_reply                    want;
    int                        errors;
    int                        beats_sent;
    int                        size_writes;
    int                        idle_pct;
    int                        status_count [8];

    open_addressing_hash_table_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_command  (i_command),
        .i_key      (i_key),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_slot     (o_slot)
    );

    always #6 i_clk = ~i_clk;

    function automatic int unsigned probe_slot(int unsigned home, int unsigned k,
                                               int unsigned s);
        return (home + (cfg_quad ? k * k : k)) % s;
    endfunction

    task automatic hash_apply(input logic [oah_pkg::CMD_W-1:0] cmd,
                              input logic [oah_pkg::KEY_W-1:0] key,
                              output t_reply r);
        int unsigned s;
        int unsigned home;
        int unsigned k;
        int unsigned j;
        int unsigned where;
        bit          hit;
        s = (cfg_size == 0) ? 1 :
            (cfg_size > oah_pkg::SLOT_COUNT) ? oah_pkg::SLOT_COUNT : cfg_size;
        home  = key % s;
        hit   = 1'b0;
        where = 0;
        r     = '0;
        // lookup walks past deleted slots and stops on the first empty one
        for (k = 0; k < s; k++) begin
            j = probe_slot(home, k, s);
            if (tbl_mark[j] == oah_pkg::MARK_EMPTY) break;
            if (tbl_mark[j] == oah_pkg::MARK_USED && tbl_key[j] == key) begin
                hit   = 1'b1;
                where = j;
                break;
            end
        end
        case (cmd)
            oah_pkg::CMD_INSERT: begin
                if (hit) begin
                    r.status = oah_pkg::ST_EXISTS;
                    r.slot   = where[oah_pkg::SLOT_W-1:0];
                end else begin
                    r.status = oah_pkg::ST_FULL;
                    for (k = 0; k < s; k++) begin
                        j = probe_slot(home, k, s);
                        if (tbl_mark[j] != oah_pkg::MARK_USED) begin
                            tbl_mark[j] = oah_pkg::MARK_USED;
                            tbl_key[j]  = key;
                            r.status    = oah_pkg::ST_INSERTED;
                            r.slot      = j[oah_pkg::SLOT_W-1:0];
                            break;
                        end
                    end
                end
            end
            oah_pkg::CMD_DELETE: begin
                if (hit) begin
                    tbl_mark[where] = oah_pkg::MARK_GONE;
                    r.status        = oah_pkg::ST_DELETED;
                    r.slot          = where[oah_pkg::SLOT_W-1:0];
                end else begin
                    r.status = oah_pkg::ST_NOT_EXISTS;
                end
            end
            default: begin
                if (hit) begin
                    r.status = oah_pkg::ST_FOUND;
                    r.slot   = where[oah_pkg::SLOT_W-1:0];
                end else begin
                    r.status = oah_pkg::ST_NOT_FOUND;
                end
            end
        endcase
    endtask

    function automatic t_row op_row(logic [oah_pkg::CMD_W-1:0] cmd,
                                    logic [oah_pkg::KEY_W-1:0] key,
                                    logic typed, logic [oah_pkg::STATUS_W-1:0] st,
                                    logic [oah_pkg::SLOT_W-1:0] sl);
        return {1'b0, cmd, key, typed, st, sl};
    endfunction

    function automatic t_row cfg_row(logic [0:0] idx, logic [oah_pkg::SIZE_W-1:0] data);
        return {1'b1, 1'b0, idx, {(oah_pkg::KEY_W-oah_pkg::SIZE_W){1'b0}}, data, 1'b0,
                {(oah_pkg::STATUS_W+oah_pkg::SLOT_W){1'b0}}};
    endfunction

    // present one command beat and hold it until the block takes it
    task automatic send_cmd(input logic [oah_pkg::CMD_W-1:0] cmd,
                            input logic [oah_pkg::KEY_W-1:0] key,
                            input logic typed, input t_reply typed_reply);
        t_reply pred;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_key     <= key;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        hash_apply(cmd, key, pred);
        replies_due.push_back(typed ? typed_reply : pred);
        beats_sent++;
    endtask

    // drop start and wait until every reply is back and the block is idle
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (replies_due.size() != 0 || busy) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [oah_pkg::SIZE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == oah_pkg::REG_PROBE_MODE) begin
            cfg_quad = data[0];
        end else begin
            cfg_size = data;
            size_writes++;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (replies_due.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected reply: status %0d slot %0d", o_status, o_slot);
            end else begin
                want = replies_due.pop_front();
                status_count[want.status]++;
                if (o_status !== want.status || o_slot !== want.slot) begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("mismatch at %0t: status exp %0d got %0d, slot exp %0d got %0d",
                                 $realtime, want.status, o_status, want.slot, o_slot);
                end
            end
        end
    end

    initial begin
        #12_000_000;
        $display("timeout with %0d replies outstanding", replies_due.size());
        $display("** open_addressing_hash_table_top: FAILED **");
        $finish;
    end

    initial begin
        int                         i;
        int                         p;
        int                         n;
        int unsigned                s;
        int unsigned                pick;
        logic [oah_pkg::SIZE_W-1:0] size_sel;
        logic [oah_pkg::CMD_W-1:0]  cmd;
        logic [oah_pkg::KEY_W-1:0]  key;
        t_row                       row;

        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_command  = oah_pkg::CMD_INSERT;
        i_key      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = oah_pkg::REG_PROBE_MODE;
        i_cfg_data = '0;
        idle_pct   = 0;
        for (i = 0; i < oah_pkg::SLOT_COUNT; i++) begin
            tbl_mark[i] = oah_pkg::MARK_EMPTY;
            tbl_key[i]  = '0;
        end
        cfg_quad = 1'b0;
        cfg_size = 7'd64;

        // directed: basic flow, tombstones, wrap, key zero, spare command, size edges
        directed_rows.push_back(op_row(oah_pkg::CMD_FIND,   31'd5,  1'b1,
                                       oah_pkg::ST_NOT_FOUND,  6'd0));
        directed_rows.push_back(op_row(oah_pkg::CMD_INSERT, 31'd5,  1'b1,
                                       oah_pkg::ST_INSERTED,   6'd5));
        directed_rows.push_back(op_row(oah_pkg::CMD_INSERT, 31'd5,  1'b1,
                                       oah_pkg::ST_EXISTS,     6'd5));
        directed_rows.push_back(op_row(oah_pkg::CMD_FIND,   31'd5,  1'b1,
                                       oah_pkg::ST_FOUND,      6'd5));
        directed_rows.push_back(op_row(oah_pkg::CMD_DELETE, 31'd5,  1'b1,
                                       oah_pkg::ST_DELETED,    6'd5));
        directed_rows.push_back(op_row(oah_pkg::CMD_DELETE, 31'd5,  1'b1,
                                       oah_pkg::ST_NOT_EXISTS, 6'd0));
        directed_rows.push_back(op_row(oah_pkg::CMD_FIND,   31'd5,  1'b1,
                                       oah_pkg::ST_NOT_FOUND,  6'd0));
        directed_rows.push_back(op_row(oah_pkg::CMD_INSERT, 31'd0,  1'b1,
                                       oah_pkg::ST_INSERTED,   6'd0));
        directed_rows.push_back(op_row(oah_pkg::CMD_INSERT, 31'd64, 1'b1,
                                       oah_pkg::ST_INSERTED,   6'd1));
        directed_rows.push_back(op_row(oah_pkg::CMD_INSERT, 31'h7FFF_FFFF, 1'b1,
                                       oah_pkg::ST_INSERTED,   6'd63));
        directed_rows.push_back(op_row(oah_pkg::CMD_INSERT, 31'd127, 1'b1,
                                       oah_pkg::ST_INSERTED,   6'd2));
        directed_rows.push_back(op_row(CMD_SPARE,           31'd0,  1'b1,
                                       oah_pkg::ST_FOUND,      6'd0));
        directed_rows.push_back(op_row(oah_pkg::CMD_INSERT, 31'd69, 1'b1,
                                       oah_pkg::ST_INSERTED,   6'd5));
        directed_rows.push_back(cfg_row(oah_pkg::REG_TABLE_SIZE, 7'd1));
        directed_rows.push_back(op_row(oah_pkg::CMD_INSERT, 31'd7,  1'b1,
                                       oah_pkg::ST_FULL,       6'd0));
        directed_rows.push_back(op_row(oah_pkg::CMD_FIND,   31'd0,  1'b1,
                                       oah_pkg::ST_FOUND,      6'd0));
        directed_rows.push_back(op_row(oah_pkg::CMD_DELETE, 31'd0,  1'b1,
                                       oah_pkg::ST_DELETED,    6'd0));
        directed_rows.push_back(op_row(oah_pkg::CMD_INSERT, 31'd7,  1'b1,
                                       oah_pkg::ST_INSERTED,   6'd0));
        directed_rows.push_back(op_row(oah_pkg::CMD_FIND,   31'd9,  1'b1,
                                       oah_pkg::ST_NOT_FOUND,  6'd0));
        directed_rows.push_back(op_row(oah_pkg::CMD_DELETE, 31'd9,  1'b1,
                                       oah_pkg::ST_NOT_EXISTS, 6'd0));
        directed_rows.push_back(cfg_row(oah_pkg::REG_TABLE_SIZE, 7'd0));
        directed_rows.push_back(op_row(oah_pkg::CMD_FIND,   31'd7,  1'b1,
                                       oah_pkg::ST_FOUND,      6'd0));
        directed_rows.push_back(cfg_row(oah_pkg::REG_TABLE_SIZE, 7'd127));
        directed_rows.push_back(op_row(oah_pkg::CMD_FIND,   31'd127, 1'b0,
                                       oah_pkg::ST_INSERTED,   6'd0));
        directed_rows.push_back(cfg_row(oah_pkg::REG_PROBE_MODE, 7'd1));
        directed_rows.push_back(cfg_row(oah_pkg::REG_TABLE_SIZE, 7'd64));
        directed_rows.push_back(op_row(oah_pkg::CMD_FIND,   31'd64, 1'b0,
                                       oah_pkg::ST_INSERTED,   6'd0));
        directed_rows.push_back(op_row(oah_pkg::CMD_INSERT, 31'd128, 1'b0,
                                       oah_pkg::ST_INSERTED,   6'd0));
        directed_rows.push_back(op_row(oah_pkg::CMD_INSERT, 31'h7FFF_FFC0, 1'b0,
                                       oah_pkg::ST_INSERTED,   6'd0));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.cfg) begin
                settle();
                write_reg(row.op[0], row.arg[oah_pkg::SIZE_W-1:0]);
            end else begin
                send_cmd(row.op, row.arg, row.typed, row.reply);
            end
        end

        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       size_sel = 7'd64;
                1:       size_sel = 7'd1;
                2:       size_sel = 7'd7;
                3:       size_sel = 7'd16;
                4:       size_sel = 7'd0;
                5:       size_sel = 7'd127;
                6:       size_sel = 7'd5;
                7:       size_sel = 7'd3;
                8:       size_sel = 7'd13;
                9:       size_sel = 7'd2;
                10:      size_sel = 7'd100;
                default: size_sel = 7'd31;
            endcase
            case (p % 4)
                1:       idle_pct = 84;
                3:       idle_pct = 21;
                default: idle_pct = 0;
            endcase
            settle();
            write_reg(oah_pkg::REG_PROBE_MODE, {6'd0, p[0] ^ p[2]});
            write_reg(oah_pkg::REG_TABLE_SIZE, size_sel);
            s = (size_sel == 0) ? 1 :
                (size_sel > oah_pkg::SLOT_COUNT) ? oah_pkg::SLOT_COUNT : size_sel;
            for (n = 0; n < PER_PHASE; n++) begin
                pick = $urandom_range(99);
                if (pick < 45)      cmd = oah_pkg::CMD_INSERT;
                else if (pick < 70) cmd = oah_pkg::CMD_DELETE;
                else if (pick < 95) cmd = oah_pkg::CMD_FIND;
                else                cmd = CMD_SPARE;
                // reuse recently inserted keys most of the time so finds and deletes hit
                pick = $urandom_range(99);
                if (pick < 55 && key_pool.size() != 0)
                    key = key_pool[$urandom_range(key_pool.size() - 1)];
                else if (pick < 85)
                    key = oah_pkg::KEY_W'($urandom_range(4 * s + 3));
                else
                    key = oah_pkg::KEY_W'($urandom);
                send_cmd(cmd, key, 1'b0, '0);
                if (cmd == oah_pkg::CMD_INSERT) begin
                    key_pool.push_back(key);
                    if (key_pool.size() > 24) void'(key_pool.pop_front());
                end
            end
        end

        settle();
        repeat (170) @(posedge i_clk);

        $display("Ran %0d commands across %0d table size settings, both probe modes.",
                 beats_sent, size_writes);
        $display("Replies: ins %0d dup %0d full %0d del %0d miss-del %0d hit %0d miss %0d; bad %0d",
                 status_count[oah_pkg::ST_INSERTED], status_count[oah_pkg::ST_EXISTS],
                 status_count[oah_pkg::ST_FULL], status_count[oah_pkg::ST_DELETED],
                 status_count[oah_pkg::ST_NOT_EXISTS], status_count[oah_pkg::ST_FOUND],
                 status_count[oah_pkg::ST_NOT_FOUND], errors);
        if (errors == 0 && replies_due.size() == 0) begin
            $display("** open_addressing_hash_table_top: PASSED **");
        end else begin
            $display("** open_addressing_hash_table_top: FAILED **");
        end
        $finish;
    end

endmodule
